// ===== rtl/ufsr_pkg.sv =====
// Package: shared types, constants and codes of the unit fraction sum reducer.
package ufsr_pkg;

  localparam int MaxTerms = 7;
  localparam int DenBits  = 8;
  localparam int InDenW   = 8;
  localparam int NumW     = 59;
  localparam int DenW     = 56;
  localparam int ErrW     = 2;
  localparam int CntW     = $clog2(MaxTerms + 1);
  localparam int StepW    = $clog2(NumW);

  localparam logic [ErrW-1:0] ERR_NONE     = 2'd0;
  localparam logic [ErrW-1:0] ERR_ZERO_DEN = 2'd1;
  localparam logic [ErrW-1:0] ERR_TOO_MANY = 2'd2;

  typedef struct packed {
    logic [InDenW-1:0] denominator;
    logic              last_term;
  } ufsr_in_t;

  typedef struct packed {
    logic [NumW-1:0] sum_numerator;
    logic [DenW-1:0] sum_denominator;
    logic [ErrW-1:0] error_code;
  } ufsr_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_GCD,
    S_GFIN,
    S_DIVN,
    S_SAVE,
    S_DIVD,
    S_EMIT
  } ufsr_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic upd;       // fold the accepted term into the group sums
    logic gcd_load;  // seed the gcd registers from the group sums
    logic gcd_step;  // one binary gcd step
    logic g_load;    // form the gcd from the finished registers
    logic div_load;  // seed the divider
    logic div_den;   // divider dividend is the product (else the numerator)
    logic div_step;  // one restoring division step
    logic save_num;  // keep the numerator quotient
    logic load_out;  // write the result register
    logic clear;     // return the group state to its reset values
  } ufsr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic trivial;   // group error set or no term accumulated
    logic gcd_done;  // one gcd operand reached zero
    logic div_last;  // final division step this cycle
  } ufsr_sts_t;

endpackage

// ===== rtl/ufsr_datapath.sv =====
// Datapath: group accumulators, binary gcd unit, restoring divider, result register.
module ufsr_datapath
  import ufsr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ufsr_in_t  in_data_i,
  input  ufsr_cmd_t cmd_i,
  output ufsr_sts_t sts_o,
  output ufsr_out_t out_data_o
);

  logic [NumW-1:0]  num_q, num_d;
  logic [DenW-1:0]  prod_q, prod_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [ErrW-1:0]  err_q, err_d;

  logic [NumW-1:0]  a_q, a_d, b_q, b_d, g_q, g_d, gor;
  logic [StepW-1:0] k_q, k_d;

  logic [NumW-1:0]  rem_q, rem_d, quo_q, quo_d, res_num_q, res_num_d;
  logic [StepW-1:0] step_q, step_d;
  logic [NumW:0]    trial;
  logic             qbit;

  logic [DenBits-1:0]      d;
  logic [NumW+DenBits-1:0] mul_num;
  logic [DenW+DenBits-1:0] mul_prod;

  ufsr_out_t out_q, out_d;

  assign d        = in_data_i.denominator[DenBits-1:0];
  assign mul_num  = (NumW+DenBits)'(num_q) * (NumW+DenBits)'(d);
  assign mul_prod = (DenW+DenBits)'(prod_q) * (DenW+DenBits)'(d);

  // Group accumulation.
  always_comb begin
    num_d  = num_q;
    prod_d = prod_q;
    cnt_d  = cnt_q;
    err_d  = err_q;
    if (cmd_i.clear) begin
      num_d  = '0;
      prod_d = DenW'(1);
      cnt_d  = '0;
      err_d  = ERR_NONE;
    end else if (cmd_i.upd && err_q == ERR_NONE) begin
      if (cnt_q >= CntW'(MaxTerms)) begin
        err_d = ERR_TOO_MANY;
      end else if (d == '0) begin
        err_d = ERR_ZERO_DEN;
      end else begin
        num_d  = mul_num[NumW-1:0] + NumW'(prod_q);
        prod_d = mul_prod[DenW-1:0];
        cnt_d  = cnt_q + CntW'(1);
      end
    end
  end

  // Binary gcd: shift out common and single factors of two, subtract odd pairs.
  assign gor = (a_q | b_q) << k_q;

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    k_d = k_q;
    g_d = g_q;
    if (cmd_i.gcd_load) begin
      a_d = num_q;
      b_d = NumW'(prod_q);
      k_d = '0;
    end else if (cmd_i.gcd_step) begin
      case ({a_q[0], b_q[0]})
        2'b00: begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + StepW'(1);
        end
        2'b01: a_d = a_q >> 1;
        2'b10: b_d = b_q >> 1;
        default: begin
          if (a_q >= b_q) begin
            a_d = a_q - b_q;
          end else begin
            b_d = b_q - a_q;
          end
        end
      endcase
    end
    if (cmd_i.g_load) begin
      g_d = (gor == '0) ? NumW'(1) : gor;
    end
  end

  // Restoring divider, one quotient bit a step, dividend shifted out of quo.
  assign trial = {rem_q, quo_q[NumW-1]};
  assign qbit  = (trial >= {1'b0, g_q});

  always_comb begin
    rem_d     = rem_q;
    quo_d     = quo_q;
    step_d    = step_q;
    res_num_d = res_num_q;
    if (cmd_i.save_num) begin
      res_num_d = quo_q;
    end
    if (cmd_i.div_load) begin
      rem_d  = '0;
      quo_d  = cmd_i.div_den ? NumW'(prod_q) : num_q;
      step_d = '0;
    end else if (cmd_i.div_step) begin
      rem_d  = qbit ? NumW'(trial - {1'b0, g_q}) : trial[NumW-1:0];
      quo_d  = {quo_q[NumW-2:0], qbit};
      step_d = step_q + StepW'(1);
    end
  end

  // Result register.
  always_comb begin
    out_d = out_q;
    if (cmd_i.load_out) begin
      if (sts_o.trivial) begin
        out_d.sum_numerator   = '0;
        out_d.sum_denominator = '0;
        out_d.error_code      = err_q;
      end else begin
        out_d.sum_numerator   = res_num_q;
        out_d.sum_denominator = quo_q[DenW-1:0];
        out_d.error_code      = ERR_NONE;
      end
    end
  end

  assign sts_o.trivial  = (err_q != ERR_NONE) || (cnt_q == '0);
  assign sts_o.gcd_done = (a_q == '0) || (b_q == '0);
  assign sts_o.div_last = (step_q == StepW'(NumW - 1));
  assign out_data_o     = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= '0;
      prod_q <= DenW'(1);
      cnt_q  <= '0;
      err_q  <= ERR_NONE;
    end else begin
      num_q  <= num_d;
      prod_q <= prod_d;
      cnt_q  <= cnt_d;
      err_q  <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    b_q       <= b_d;
    k_q       <= k_d;
    g_q       <= g_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    step_q    <= step_d;
    res_num_q <= res_num_d;
    out_q     <= out_d;
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxTerms))
    else $error("term count beyond the limit");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q != 2'd3)
    else $error("illegal group error code");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> g_q != '0)
    else $error("division by a zero gcd");

  a_err_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ERR_NONE && !cmd_i.clear) |=> $stable(num_q) && $stable(cnt_q))
    else $error("group sums moved after an error");
`endif

endmodule

// ===== rtl/ufsr_ctrl.sv =====
// Controller: sequencing of accumulation, gcd, two divisions and result hand-off.
module ufsr_ctrl
  import ufsr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_last_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  ufsr_sts_t sts_i,
  output ufsr_cmd_t cmd_o
);

  ufsr_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept, out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.upd = 1'b1;
          if (in_last_i) begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sts_i.trivial) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.gcd_load = 1'b1;
          state_d        = S_GCD;
        end
      end
      S_GCD: begin
        if (sts_i.gcd_done) begin
          state_d = S_GFIN;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      S_GFIN: begin
        cmd_o.g_load   = 1'b1;
        cmd_o.div_load = 1'b1;
        state_d        = S_DIVN;
      end
      S_DIVN: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_SAVE;
        end
      end
      S_SAVE: begin
        cmd_o.save_num = 1'b1;
        cmd_o.div_load = 1'b1;
        cmd_o.div_den  = 1'b1;
        state_d        = S_DIVD;
      end
      S_DIVD: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.clear    = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/unit_fraction_sum_reducer_top.sv =====
// Top level: unit fraction sum reducer, controller plus datapath.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  in      | input     | in_valid_i/in_stall_o  | ufsr_in_t: denominator, last_term
//  out     | output    | out_valid_o/out_stall_i| ufsr_out_t: sum_numerator,
//          |           |                      |   sum_denominator, error_code
//
// A term without last_term is folded into the group sums at the edge of its
// transfer and the next term may follow right away.
// A last term runs the binary gcd, one compare-and-subtract per cycle, and then
// the two divisions; every subtract is followed by a shift and the two sums hold
// at most 107 bits between them.
// The two divisions share one restoring divider that makes one quotient bit per cycle.
// An error group or a group without terms skips gcd and divisions.
// Reset clears the controller and returns the group sums to zero over one.
// A stalled result holds in the output register; terms of the next group are
// still taken until its last term needs that register.
module unit_fraction_sum_reducer_top
  import ufsr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ufsr_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ufsr_out_t out_data_o
);

  ufsr_cmd_t cmd;
  ufsr_sts_t sts;

  // Sequence each group: accumulate terms, then gcd, divide, emit.
  ufsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last_term),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hold the group sums, gcd and divider registers and the result register.
  ufsr_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

`ifndef ASSERT_OFF
  a_err_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.error_code != ERR_NONE) |->
      (out_data_o.sum_numerator == '0 && out_data_o.sum_denominator == '0))
    else $error("error result with nonzero sums");

  a_ok_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.error_code == ERR_NONE) |->
      out_data_o.sum_denominator != '0)
    else $error("clean result with zero denominator");

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.last_term) |=> in_stall_o)
    else $error("input not held off after a last term");
`endif

endmodule
